/* hw/rtl/plfc_pkg.sv */
// ----------------------------------------------------------------------------
// plfc_pkg
// Shared widths, mode codes and register map of the PMBus linear converter.
// ----------------------------------------------------------------------------
package plfc_pkg;

  // payload widths
  localparam int MODE_W  = 2;
  localparam int WORD_W  = 16;
  localparam int VALUE_W = 48;
  localparam int EXP_W   = 5;

  // default number of fraction bits of the fixed-point side
  localparam int FRACTION_BITS_DEF = 16;

  // conversion modes
  localparam logic [MODE_W-1:0] MODE_DEC_SL11 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENC_SL11 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEC_UL16 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ENC_UL16 = 2'd3;

  // slinear11 layout and limits
  localparam int SL_MANT_W   = 11;
  localparam int SL_EXP_BIAS = 15;
  localparam int SL_NUM_EXP  = 31;
  localparam logic [SL_MANT_W-1:0] SL_POS_LIM = 11'd1023;
  localparam logic [SL_MANT_W-1:0] SL_NEG_LIM = 11'd1024;
  localparam logic [EXP_W-1:0]     SL_EXP_MAX = 5'd15;

  // configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VOUT_EXPONENT = 1'd0;
  localparam logic signed [EXP_W-1:0] VOUT_EXP_RESET = -5'sd9;

endpackage

/* hw/rtl/plfc_in_if.sv */
// ----------------------------------------------------------------------------
// plfc_in_if
// Request channel: conversion mode, PMBus word and fixed-point value.
// ----------------------------------------------------------------------------
interface plfc_in_if;
  import plfc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [WORD_W-1:0]         raw_word;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, output mode, output raw_word, output value_in,
                  input ready);
  modport sink   (input valid, input mode, input raw_word, input value_in,
                  output ready);

endinterface

/* hw/rtl/plfc_out_if.sv */
// ----------------------------------------------------------------------------
// plfc_out_if
// Result channel: decoded value, encoded word and saturation flag.
// ----------------------------------------------------------------------------
interface plfc_out_if;
  import plfc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [WORD_W-1:0]         word_out;
  logic                      clipped;

  modport source (output valid, output value_out, output word_out, output clipped,
                  input ready);
  modport sink   (input valid, input value_out, input word_out, input clipped,
                  output ready);

endinterface

/* hw/rtl/pmbus_linear_format_converter.sv */
// ----------------------------------------------------------------------------
// pmbus_linear_format_converter
// Converts between signed fixed-point values and PMBus SLINEAR11 / ULINEAR16
// words, one item per cycle while the result side keeps taking them.
// ----------------------------------------------------------------------------
// Every request word produces one result word, registered first in the input
// register and then in the result register, with the exponent search, the
// shifter and the saturation logic between them. A new word is accepted
// every cycle as long as the result side keeps taking words; a stalled
// result holds the pipeline, and the input register still takes one word
// while the result register waits. ULINEAR16 words use the exponent held
// in the vout_exponent register (byte address 0, reset -9), which should only
// be written while no conversion is in flight.
module pmbus_linear_format_converter #(
  parameter int FRACTION_BITS = plfc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  plfc_in_if.sink                       in_ch,
  plfc_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [plfc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [plfc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [plfc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import plfc_pkg::*;

  localparam int MAX_SHIFT = FRACTION_BITS + SL_EXP_BIAS;
  localparam int SH_W      = $clog2(MAX_SHIFT + 1);
  localparam int DEC_W     = WORD_W + MAX_SHIFT;
  localparam int EXT_W     = (DEC_W > VALUE_W) ? DEC_W + 1 : VALUE_W + 1;
  localparam int THR_W     = MAX_SHIFT + SL_MANT_W + 1;
  localparam int CMP_W     = (THR_W > VALUE_W) ? THR_W : VALUE_W;
  localparam int SEL_W     = EXP_W;
  localparam logic [EXT_W-1:0] NEG_SAT = EXT_W'(1) << (VALUE_W - 1);
  localparam logic [EXT_W-1:0] POS_SAT = NEG_SAT - EXT_W'(1);

  // exponent to shift count, floored at zero
  function automatic logic [SH_W-1:0] exp_shift(input logic [EXP_W-1:0] e);
    logic signed [SH_W:0] s;
    s = (SH_W+1)'(FRACTION_BITS) + {{(SH_W+1-EXP_W){e[EXP_W-1]}}, e};
    exp_shift = s[SH_W] ? '0 : s[SH_W-1:0];
  endfunction

  // configuration register
  logic [EXP_W-1:0] vexp_r, vexp_nxt;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    vexp_nxt = vexp_r;
    if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_VOUT_EXPONENT)) begin
      vexp_nxt = cfg_pwdata[EXP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1:2] == REG_VOUT_EXPONENT) begin
      cfg_prdata = CFG_DW'(vexp_r);
    end
  end

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv;
  logic in_rdy;

  assign adv    = !out_valid_r || out_ch.ready;
  assign in_rdy = !s1_valid_r || adv;
  assign in_ch.ready = in_rdy;

  always_comb begin
    s1_valid_nxt  = in_rdy ? in_ch.valid : s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vexp_r      <= VOUT_EXP_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vexp_r      <= vexp_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  logic [MODE_W-1:0]  s1_mode_r;
  logic [WORD_W-1:0]  s1_raw_r;
  logic [VALUE_W-1:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_raw_r  <= in_ch.raw_word;
      s1_val_r  <= in_ch.value_in;
    end
  end

  // decode path
  logic                 dec_neg;
  logic [SL_MANT_W-1:0] sl_mmag;
  logic [WORD_W-1:0]    dec_mag;
  logic [SH_W-1:0]      dec_sh;
  logic [EXT_W-1:0]     dec_wide;
  logic [EXT_W-1:0]     dec_sat;
  logic [VALUE_W-1:0]   dec_val;

  always_comb begin
    sl_mmag = s1_raw_r[SL_MANT_W-1] ? (~s1_raw_r[SL_MANT_W-1:0] + SL_MANT_W'(1))
                                    : s1_raw_r[SL_MANT_W-1:0];
    if (s1_mode_r == MODE_DEC_SL11) begin
      dec_neg = s1_raw_r[SL_MANT_W-1];
      dec_mag = WORD_W'(sl_mmag);
      dec_sh  = exp_shift(s1_raw_r[WORD_W-1:SL_MANT_W]);
    end else begin
      dec_neg = 1'b0;
      dec_mag = s1_raw_r;
      dec_sh  = exp_shift(vexp_r);
    end
    dec_wide = EXT_W'(dec_mag) << dec_sh;
    // clamp to the 48-bit range before applying the sign
    if (dec_neg) begin
      dec_sat = (dec_wide > NEG_SAT) ? NEG_SAT : dec_wide;
      dec_val = VALUE_W'(~dec_sat + EXT_W'(1));
    end else begin
      dec_sat = (dec_wide > POS_SAT) ? POS_SAT : dec_wide;
      dec_val = dec_sat[VALUE_W-1:0];
    end
  end

  // encode path: sign and magnitude of the fixed-point value
  logic                 x_neg;
  logic [VALUE_W-1:0]   x_mag;

  assign x_neg = s1_val_r[VALUE_W-1];
  assign x_mag = x_neg ? (~s1_val_r + VALUE_W'(1)) : s1_val_r;

  // slinear11: smallest exponent whose truncated mantissa fits
  logic [SL_MANT_W-1:0]  sl_lim;
  logic [SL_MANT_W:0]    sl_lim1;
  logic [SL_NUM_EXP-1:0] sl_fits;
  logic [SEL_W-1:0]      sl_sel;
  logic                  sl_fit;
  logic [SH_W-1:0]       sl_sh;
  logic [VALUE_W-1:0]    sl_shifted;
  logic [SL_MANT_W-1:0]  sl_m;
  logic [SL_MANT_W-1:0]  sl_mbits;
  logic [EXP_W-1:0]      sl_ebits;
  logic [WORD_W-1:0]     sl_word;

  always_comb begin
    sl_lim  = x_neg ? SL_NEG_LIM : SL_POS_LIM;
    sl_lim1 = {1'b0, sl_lim} + (SL_MANT_W+1)'(1);
    for (int k = 0; k < SL_NUM_EXP; k++) begin
      sl_fits[k] = CMP_W'(x_mag) < (CMP_W'(sl_lim1) << (FRACTION_BITS + k - SL_EXP_BIAS));
    end
    sl_sel = '0;
    for (int k = SL_NUM_EXP - 1; k >= 0; k--) begin
      if (sl_fits[k]) begin
        sl_sel = SEL_W'(k);
      end
    end
    sl_fit     = |sl_fits;
    sl_sh      = SH_W'(FRACTION_BITS - SL_EXP_BIAS) + SH_W'(sl_sel);
    sl_shifted = x_mag >> sl_sh;
    if (sl_fit) begin
      sl_m     = sl_shifted[SL_MANT_W-1:0];
      sl_ebits = sl_sel - EXP_W'(SL_EXP_BIAS);
    end else begin
      sl_m     = sl_lim;
      sl_ebits = SL_EXP_MAX;
    end
    sl_mbits = x_neg ? (~sl_m + SL_MANT_W'(1)) : sl_m;
    sl_word  = {sl_ebits, sl_mbits};
  end

  // ulinear16: fixed exponent, saturate to the unsigned range
  logic [SH_W-1:0]    ul_sh;
  logic [VALUE_W-1:0] ul_q;
  logic [WORD_W-1:0]  ul_word;
  logic               ul_clip;

  always_comb begin
    ul_sh = exp_shift(vexp_r);
    ul_q  = x_mag >> ul_sh;
    priority if (x_neg) begin
      ul_word = '0;
      ul_clip = |ul_q;
    end else if (|ul_q[VALUE_W-1:WORD_W]) begin
      ul_word = '1;
      ul_clip = 1'b1;
    end else begin
      ul_word = ul_q[WORD_W-1:0];
      ul_clip = 1'b0;
    end
  end

  // result select and result register
  logic [VALUE_W-1:0] value_out_r, value_out_nxt;
  logic [WORD_W-1:0]  word_out_r, word_out_nxt;
  logic               clipped_r, clipped_nxt;

  always_comb begin
    value_out_nxt = '0;
    word_out_nxt  = '0;
    clipped_nxt   = 1'b0;
    unique case (s1_mode_r)
      MODE_DEC_SL11, MODE_DEC_UL16: begin
        value_out_nxt = dec_val;
      end
      MODE_ENC_SL11: begin
        word_out_nxt = sl_word;
        clipped_nxt  = !sl_fit;
      end
      MODE_ENC_UL16: begin
        word_out_nxt = ul_word;
        clipped_nxt  = ul_clip;
      end
      default: begin
        value_out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      value_out_r <= value_out_nxt;
      word_out_r  <= word_out_nxt;
      clipped_r   <= clipped_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = value_out_r;
  assign out_ch.word_out  = word_out_r;
  assign out_ch.clipped   = clipped_r;

endmodule

/* tb/sv/pmbus_linear_format_converter_test.sv */
// ----------------------------------------------------------------------------
// pmbus_linear_format_converter_test
// Self-checking bench for the PMBus SLINEAR11 / ULINEAR16 converter. A short
// table of corner words and values runs first, then phases of random
// conversions under several vout_exponent settings. Every result word is
// compared field by field with a local conversion model or with the literal
// result of a typed corner row, while both channels idle at random outside the no_idle phase.
// ----------------------------------------------------------------------------
module pmbus_linear_format_converter_test;
  import plfc_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 215;
  localparam logic [CFG_AW-1:0] VOUT_EXP_ADDR = CFG_AW'(REG_VOUT_EXPONENT) << 2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [WORD_W-1:0]  raw;
    logic [VALUE_W-1:0] value;
  } conv_request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [WORD_W-1:0]  word;
    logic               clip;
  } conv_result_t;

  typedef struct packed {
    conv_request_t rq;
    logic          typed;
    conv_result_t  lit;
  } corner_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  plfc_in_if  in_ch ();
  plfc_out_if out_ch ();

  pmbus_linear_format_converter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [EXP_W-1:0] vout_exp_shadow = VOUT_EXP_RESET;
  conv_result_t     pending_results[$];
  corner_row_t      corner_rows[$];
  bit               no_idle = 1'b0;
  int               errors = 0;
  int               results_checked = 0;
  int               saturated_seen = 0;
  int               exp_writes = 0;
  int               mode_count[4] = '{0, 0, 0, 0};
  int unsigned      cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // conversion model: exact decodes, truncating and saturating encodes
  function automatic conv_result_t linear_convert(conv_request_t rq, logic [EXP_W-1:0] vexp);
    conv_result_t       r;
    logic               neg;
    logic [VALUE_W:0]   mag;
    logic [VALUE_W:0]   m;
    logic [VALUE_W:0]   limit;
    logic [VALUE_W-1:0] mant;
    logic [10:0]        mb;
    logic               fit;
    int                 ex;
    int                 e;
    int                 sh;
    r = '0;
    neg = rq.value[VALUE_W-1];
    mag = neg ? ((VALUE_W+1)'(0) - {1'b1, rq.value}) : {1'b0, rq.value};
    ex = $signed(vexp);
    case (rq.mode)
      MODE_DEC_SL11: begin
        ex = $signed(rq.raw[WORD_W-1:SL_MANT_W]);
        mant = {{(VALUE_W-SL_MANT_W){rq.raw[SL_MANT_W-1]}}, rq.raw[SL_MANT_W-1:0]};
        r.value = mant << (FRAC + ex);
      end
      MODE_DEC_UL16: begin
        r.value = {{(VALUE_W-WORD_W){1'b0}}, rq.raw} << (FRAC + ex);
      end
      MODE_ENC_SL11: begin
        limit = neg ? (VALUE_W+1)'(SL_NEG_LIM) : (VALUE_W+1)'(SL_POS_LIM);
        fit = 1'b0;
        e = 15;
        m = limit;
        // smallest exponent whose truncated mantissa fits
        for (int k = -15; k <= 15; k++) begin
          if (!fit) begin
            m = mag >> (FRAC + k);
            if (m <= limit) begin
              fit = 1'b1;
              e = k;
            end
          end
        end
        if (!fit) begin
          e = 15;
          m = limit;
        end
        mb = m[10:0];
        if (neg) mb = 11'd0 - mb;
        r.word = {e[EXP_W-1:0], mb};
        r.clip = !fit;
      end
      default: begin
        sh = FRAC + ex;
        m = mag >> sh;
        if (neg) begin
          r.word = '0;
          r.clip = (m != 0);
        end else if (m > 65535) begin
          r.word = 16'hFFFF;
          r.clip = 1'b1;
        end else begin
          r.word = m[WORD_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] random_fixed();
    logic [31:0]        hi;
    logic [31:0]        lo;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    int                 pick;
    int                 ex;
    hi = $urandom;
    lo = $urandom;
    v = {hi[15:0], lo};
    pick = $urandom_range(0, 3);
    ex = $signed(vout_exp_shadow);
    case (pick)
      0: ;
      1: v = v >> $urandom_range(0, VALUE_W - 1);
      2: begin
        // around the slinear11 mantissa limits at some exponent
        base = 48'd1022 + $urandom_range(0, 3);
        v = (base << $urandom_range(1, 31)) + {46'd0, lo[1:0]};
      end
      default: begin
        // around the ulinear16 full scale
        base = 48'd65534 + $urandom_range(0, 3);
        v = (base << (FRAC + ex)) + {46'd0, lo[1:0]};
      end
    endcase
    if (pick != 0 && hi[31]) v = -v;
    return v;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] raw,
                                  logic [VALUE_W-1:0] value, logic typed,
                                  logic [VALUE_W-1:0] v, logic [WORD_W-1:0] w, logic c);
    corner_row_t row;
    row.rq.mode = mode;
    row.rq.raw = raw;
    row.rq.value = value;
    row.typed = typed;
    row.lit.value = v;
    row.lit.word = w;
    row.lit.clip = c;
    corner_rows.push_back(row);
  endfunction

  task automatic send_request(input conv_request_t rq, input logic typed,
                              input conv_result_t lit);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= rq.mode;
    in_ch.raw_word <= rq.raw;
    in_ch.value_in <= rq.value;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(typed ? lit : linear_convert(rq, vout_exp_shadow));
    mode_count[rq.mode] = mode_count[rq.mode] + 1;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // optional write, then read back and compare with the shadow copy
  task automatic access_vout_exponent(input logic do_write, input logic [EXP_W-1:0] e);
    logic [CFG_DW-1:0] rd;
    if (do_write) begin
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b1;
      cfg_paddr <= VOUT_EXP_ADDR;
      cfg_pwdata <= {{(CFG_DW-EXP_W){e[EXP_W-1]}}, e};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      vout_exp_shadow = e;
      exp_writes++;
    end
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= VOUT_EXP_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[EXP_W-1:0] !== vout_exp_shadow) begin
      errors++;
      $display("%0t: vout_exponent readback expected %h actual %h",
               $time, vout_exp_shadow, rd[EXP_W-1:0]);
    end
  endtask

  // result side: random stalls, every word checked against the oldest prediction
  initial begin
    int           stall;
    conv_result_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (out_ch.clipped === 1'b1) saturated_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h word %h clipped %b",
                 $time, out_ch.value_out, out_ch.word_out, out_ch.clipped);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_ch.value_out !== want.value) begin
          errors++;
          $display("%0t: value_out expected %h actual %h", $time, want.value, out_ch.value_out);
        end
        if (out_ch.word_out !== want.word) begin
          errors++;
          $display("%0t: word_out expected %h actual %h", $time, want.word, out_ch.word_out);
        end
        if (out_ch.clipped !== want.clip) begin
          errors++;
          $display("%0t: clipped expected %b actual %b", $time, want.clip, out_ch.clipped);
        end
      end
    end
  end

  initial begin
    conv_request_t rq;
    conv_result_t  none;
    int            ex;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_DEC_SL11;
    in_ch.raw_word <= '0;
    in_ch.value_in <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    none = '0;

    // corner table, run at the reset exponent (-9)
    add_row(MODE_DEC_SL11, 16'h0000, '0, 1, 48'h0000_0000_0000, '0, 0);
    add_row(MODE_DEC_SL11, 16'h03FF, '0, 1, 48'h0000_03FF_0000, '0, 0);
    add_row(MODE_DEC_SL11, 16'h0400, '0, 1, 48'hFFFF_FC00_0000, '0, 0);
    add_row(MODE_DEC_SL11, 16'h7BFF, '0, 0, '0, '0, 0);
    add_row(MODE_DEC_SL11, 16'h8400, '0, 1, 48'hFFFF_FFFF_FC00, '0, 0);
    add_row(MODE_DEC_SL11, 16'h83FF, '0, 0, '0, '0, 0);
    add_row(MODE_DEC_SL11, 16'hFFFF, '0, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'hFFFF, 48'd0, 1, '0, 16'h8800, 0);
    add_row(MODE_ENC_SL11, 16'h0000, 48'h7FFF_FFFF_FFFF, 1, '0, 16'h7BFF, 1);
    add_row(MODE_ENC_SL11, 16'h0000, 48'h8000_0000_0000, 1, '0, 16'h7C00, 1);
    // tiny magnitudes of both signs truncate to zero
    add_row(MODE_ENC_SL11, 16'h0000, 48'd1, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, -48'sd1, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, 48'd2046, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, 48'd2048, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, -48'sd2048, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, 48'd1023 << 31, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, 48'd1024 << 31, 0, '0, '0, 0);
    add_row(MODE_ENC_SL11, 16'h0000, -(48'sd1024 << 31), 0, '0, '0, 0);
    add_row(MODE_DEC_UL16, 16'h0000, '0, 1, 48'h0000_0000_0000, '0, 0);
    add_row(MODE_DEC_UL16, 16'hFFFF, '0, 0, '0, '0, 0);
    add_row(MODE_ENC_UL16, 16'h0000, 48'd0, 1, '0, 16'h0000, 0);
    add_row(MODE_ENC_UL16, 16'h0000, -48'sd1, 0, '0, '0, 0);
    add_row(MODE_ENC_UL16, 16'h0000, -48'sd128, 1, '0, 16'h0000, 1);
    add_row(MODE_ENC_UL16, 16'h0000, 48'h8000_0000_0000, 1, '0, 16'h0000, 1);
    add_row(MODE_ENC_UL16, 16'h0000, 48'h7FFF_FFFF_FFFF, 1, '0, 16'hFFFF, 1);
    add_row(MODE_ENC_UL16, 16'h0000, 48'd65535 << 7, 0, '0, '0, 0);
    add_row(MODE_ENC_UL16, 16'h0000, 48'd65536 << 7, 0, '0, '0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    access_vout_exponent(1'b0, '0);

    foreach (corner_rows[i])
      send_request(corner_rows[i].rq, corner_rows[i].typed, corner_rows[i].lit);
    wait_for_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: ex = -16;
        1: ex = 15;
        2: ex = 0;
        3: ex = $urandom_range(0, 31);
        4: ex = -1;
        default: ex = -9;
      endcase
      access_vout_exponent(1'b1, ex[EXP_W-1:0]);
      no_idle = (phase == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        rq.mode = MODE_W'($urandom_range(0, 3));
        rq.raw = WORD_W'($urandom);
        rq.value = random_fixed();
        send_request(rq, 1'b0, none);
        // let the pipeline run dry once mid-phase
        if (phase == 3 && n == 100) wait_for_results();
      end
      wait_for_results();
    end
    no_idle = 1'b0;

    repeat (4) @(posedge clk);
    $display("converted %0d words: %0d sl11 decode, %0d sl11 encode, %0d ul16 decode, %0d ul16 encode",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d results checked, %0d saturated, %0d exponent writes, %0d errors",
             results_checked, saturated_seen, exp_writes, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/plfc_pkg.sv
hw/rtl/plfc_in_if.sv
hw/rtl/plfc_out_if.sv
hw/rtl/pmbus_linear_format_converter.sv
tb/sv/pmbus_linear_format_converter_test.sv
